// ===== design/lcs_pkg.sv =====
// lcs_pkg: sizes, word types and table addressing for the lcs traceback core
// no dependencies; imported by every module of the block but lcs_ram

package lcs_pkg;

   localparam int MAX_LEN   = 64;
   localparam int DIM       = MAX_LEN + 1;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int VAL_W     = LEN_W;
   localparam int TBL_DEPTH = DIM * DIM;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   localparam logic WHICH_FIRST  = 1'b0;
   localparam logic WHICH_SECOND = 1'b1;

   typedef struct packed {
      logic       which_string;
      logic [7:0] char_byte;
      logic       end_of_string;
   } lcs_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_last;
      logic       is_empty;
      logic       overflowed;
   } lcs_rsp_type;

   typedef struct packed {
      logic        valid;
      lcs_rsp_type word;
   } lcs_push_type;

   // row-major address of table entry (r, c)
   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LEN_W-1:0] r,
                                                  input logic [LEN_W-1:0] c);
      return TBL_AW'(r) * TBL_AW'(DIM) + TBL_AW'(c);
   endfunction

endpackage

// ===== design/lcs_ram.sv =====
// lcs_ram: generic single write port, single read port ram with registered read
// no dependencies

module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/lcs_engine.sv =====
// lcs_engine: string loader, table fill and traceback sequencer
// depends on lcs_pkg and lcs_ram (two character stores and the length table)

module lcs_engine
   import lcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lcs_req_type  req_word,
   input  logic         out_free,
   output lcs_push_type push
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_ZROW, ST_ZCOL, ST_FRD, ST_FCALC, ST_TSTART, ST_TTOT,
      ST_EMPTY, ST_TA, ST_TB, ST_TC, ST_TD
   } state_type;

   state_type         state_ff, state_in;
   logic              first_done_ff, first_done_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  n_ff, n_in, m_ff, m_in;
   logic [LEN_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [VAL_W-1:0]  total_ff, total_in;
   logic [VAL_W-1:0]  diag_ff, diag_in, right_ff, right_in;
   logic [VAL_W-1:0]  here_ff, here_in, dn_ff, dn_in;

   logic              f_we, s_we, f_re, s_re, t_we, t_re;
   logic [IDX_W-1:0]  f_waddr, s_waddr, f_raddr, s_raddr;
   logic [7:0]        f_rd, s_rd;
   logic [TBL_AW-1:0] t_waddr, t_raddr;
   logic [VAL_W-1:0]  t_wdata, t_rd;

   logic              accept;
   logic [VAL_W-1:0]  cell_v;
   logic              tb_match, tb_last;
   logic [LEN_W-1:0]  i_nx, j_nx;

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(req_word.char_byte),
      .re(f_re), .raddr(f_raddr), .rdata(f_rd)
   );

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(req_word.char_byte),
      .re(s_re), .raddr(s_raddr), .rdata(s_rd)
   );

   lcs_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_table (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .re(t_re), .raddr(t_raddr), .rdata(t_rd)
   );

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;

   // fill recurrence: diag and right come from registers, down from the ram
   assign cell_v = (f_rd == s_rd) ? diag_ff + VAL_W'(1)
                                  : ((t_rd > right_ff) ? t_rd : right_ff);

   assign tb_match = (f_rd == s_rd) && ((t_rd + VAL_W'(1)) == here_ff);
   assign tb_last  = ((k_ff + LEN_W'(1)) == LEN_W'(total_ff));

   always_comb begin
      state_in      = state_ff;
      first_done_in = first_done_ff;
      ovf_in        = ovf_ff;
      n_in          = n_ff;
      m_in          = m_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      total_in      = total_ff;
      diag_in       = diag_ff;
      right_in      = right_ff;
      here_in       = here_ff;
      dn_in         = dn_ff;
      f_we          = 1'b0;
      s_we          = 1'b0;
      f_waddr       = n_ff[IDX_W-1:0];
      s_waddr       = m_ff[IDX_W-1:0];
      f_re          = 1'b0;
      s_re          = 1'b0;
      f_raddr       = i_ff[IDX_W-1:0];
      s_raddr       = j_ff[IDX_W-1:0];
      t_we          = 1'b0;
      t_waddr       = tbl_addr(i_ff, j_ff);
      t_wdata       = '0;
      t_re          = 1'b0;
      t_raddr       = tbl_addr(i_ff, j_ff);
      push          = '0;
      i_nx          = i_ff;
      j_nx          = j_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (!first_done_ff) begin
                  if (req_word.which_string == WHICH_FIRST) begin
                     if (n_ff < LEN_W'(MAX_LEN)) begin
                        f_we = 1'b1;
                        n_in = n_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (req_word.end_of_string) begin
                        first_done_in = 1'b1;
                     end
                  end
               end else if (req_word.which_string == WHICH_SECOND) begin
                  if (m_ff < LEN_W'(MAX_LEN)) begin
                     s_we = 1'b1;
                     m_in = m_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_word.end_of_string) begin
                     j_in     = '0;
                     state_in = ST_ZROW;
                  end
               end
            end
         end
         ST_ZROW: begin
            t_we    = 1'b1;
            t_waddr = tbl_addr(n_ff, j_ff);
            if (j_ff == m_ff) begin
               i_in     = '0;
               state_in = ST_ZCOL;
            end else begin
               j_in = j_ff + LEN_W'(1);
            end
         end
         ST_ZCOL: begin
            t_we    = 1'b1;
            t_waddr = tbl_addr(i_ff, m_ff);
            if (i_ff == n_ff) begin
               if (n_ff == '0 || m_ff == '0) begin
                  state_in = ST_TSTART;
               end else begin
                  i_in     = n_ff - LEN_W'(1);
                  j_in     = m_ff - LEN_W'(1);
                  diag_in  = '0;
                  right_in = '0;
                  state_in = ST_FRD;
               end
            end else begin
               i_in = i_ff + LEN_W'(1);
            end
         end
         ST_FRD: begin
            f_re     = 1'b1;
            s_re     = 1'b1;
            t_re     = 1'b1;
            t_raddr  = tbl_addr(i_ff + LEN_W'(1), j_ff);
            state_in = ST_FCALC;
         end
         ST_FCALC: begin
            t_we     = 1'b1;
            t_waddr  = tbl_addr(i_ff, j_ff);
            t_wdata  = cell_v;
            right_in = cell_v;
            diag_in  = t_rd;
            if (j_ff == '0) begin
               if (i_ff == '0) begin
                  state_in = ST_TSTART;
               end else begin
                  i_in     = i_ff - LEN_W'(1);
                  j_in     = m_ff - LEN_W'(1);
                  diag_in  = '0;
                  right_in = '0;
                  state_in = ST_FRD;
               end
            end else begin
               // overlap the reads of the next entry with this write
               j_in    = j_ff - LEN_W'(1);
               s_re    = 1'b1;
               s_raddr = j_in[IDX_W-1:0];
               t_re    = 1'b1;
               t_raddr = tbl_addr(i_ff + LEN_W'(1), j_in);
            end
         end
         ST_TSTART: begin
            if (n_ff == '0 || m_ff == '0) begin
               state_in = ST_EMPTY;
            end else begin
               t_re     = 1'b1;
               t_raddr  = tbl_addr('0, '0);
               state_in = ST_TTOT;
            end
         end
         ST_TTOT: begin
            total_in = t_rd;
            i_in     = '0;
            j_in     = '0;
            k_in     = '0;
            state_in = (t_rd == '0) ? ST_EMPTY : ST_TA;
         end
         ST_EMPTY: begin
            if (out_free) begin
               push.valid           = 1'b1;
               push.word.out_byte   = '0;
               push.word.is_last    = 1'b1;
               push.word.is_empty   = 1'b1;
               push.word.overflowed = ovf_ff;
               n_in                 = '0;
               m_in                 = '0;
               first_done_in        = 1'b0;
               ovf_in               = 1'b0;
               state_in             = ST_LOAD;
            end
         end
         ST_TA: begin
            f_re     = 1'b1;
            s_re     = 1'b1;
            t_re     = 1'b1;
            t_raddr  = tbl_addr(i_ff, j_ff);
            state_in = ST_TB;
         end
         ST_TB: begin
            here_in  = t_rd;
            t_re     = 1'b1;
            t_raddr  = tbl_addr(i_ff + LEN_W'(1), j_ff);
            state_in = ST_TC;
         end
         ST_TC: begin
            dn_in    = t_rd;
            t_re     = 1'b1;
            t_raddr  = tbl_addr(i_ff + LEN_W'(1), j_ff + LEN_W'(1));
            state_in = ST_TD;
         end
         ST_TD: begin
            if (tb_match) begin
               if (out_free) begin
                  push.valid           = 1'b1;
                  push.word.out_byte   = f_rd;
                  push.word.is_last    = tb_last;
                  push.word.is_empty   = 1'b0;
                  push.word.overflowed = ovf_ff;
                  k_in                 = k_ff + LEN_W'(1);
                  i_nx                 = i_ff + LEN_W'(1);
                  j_nx                 = j_ff + LEN_W'(1);
                  i_in                 = i_nx;
                  j_in                 = j_nx;
                  if (tb_last || i_nx >= n_ff || j_nx >= m_ff) begin
                     n_in          = '0;
                     m_in          = '0;
                     first_done_in = 1'b0;
                     ovf_in        = 1'b0;
                     state_in      = ST_LOAD;
                  end else begin
                     state_in = ST_TA;
                  end
               end
            end else begin
               if (dn_ff == here_ff) begin
                  i_nx = i_ff + LEN_W'(1);
               end else begin
                  j_nx = j_ff + LEN_W'(1);
               end
               i_in = i_nx;
               j_in = j_nx;
               if (i_nx >= n_ff || j_nx >= m_ff) begin
                  n_in          = '0;
                  m_in          = '0;
                  first_done_in = 1'b0;
                  ovf_in        = 1'b0;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_TA;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         first_done_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         n_ff          <= '0;
         m_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         first_done_ff <= first_done_in;
         ovf_ff        <= ovf_in;
         n_ff          <= n_in;
         m_ff          <= m_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
      end
      total_ff <= total_in;
      diag_ff  <= diag_in;
      right_ff <= right_in;
      here_ff  <= here_in;
      dn_ff    <= dn_in;
   end

endmodule

// ===== design/lcs_with_traceback_core.sv =====
// Longest common subsequence core with traceback. Words on the req_ channel load the first
// string, then the second (which_string selects, end_of_string closes each); up to 64
// characters per string are kept, more are dropped and reported through overflowed. A word
// for the string that is not currently loading is ignored. Loading takes one word per cycle.
// When the second string closes, the core zeroes the boundary row and column of the length
// table, fills the n x m suffix table in the 4225 x 7 table ram at one entry per cycle, with
// a read step (ST_FRD) at the start of each row, reads the total (ST_TSTART, ST_TTOT), then
// walks the table from the start in at most n+m-1 steps (ST_TA to ST_TD, waiting in ST_TD
// while the output register is full), and emits one rsp_ word per common character, the last one flagged
// is_last. An empty result is one word with is_empty and is_last set. No new string is
// taken until the last result word has been handed to the output register; a result word
// may wait there while the walk goes on.
// depends on lcs_pkg, lcs_engine

module lcs_with_traceback_core
   import lcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lcs_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lcs_rsp_type rsp_word
);

   lcs_push_type push;
   logic         out_free;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   lcs_rsp_type  rsp_word_ff, rsp_word_in;

   // the engine may hand over a word whenever the register is empty or empties this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   lcs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .out_free  (out_free),
      .push      (push)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (push.valid) begin
         // a push only arrives when the register is free or being drained
         rsp_valid_in = 1'b1;
         rsp_word_in  = push.word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== design/lcs_with_traceback_core_checker.sv =====
// lcs_with_traceback_core_checker: port-level assertions for the lcs traceback core
// depends on lcs_pkg; bound to lcs_with_traceback_core below

module lcs_with_traceback_core_checker
   import lcs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input lcs_req_type req_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input lcs_rsp_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // an empty result is always flagged last and carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_empty |-> rsp_word.is_last && rsp_word.out_byte == 8'd0)
      else $error("empty result not flagged last or byte not zero");

   // no loading while the walk still owes result words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.is_last |-> !req_ready)
      else $error("input taken while results pending");

   // after a non-last word is taken, loading resumes only behind the last word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_word.is_last |=>
         !req_ready || (rsp_valid && rsp_word.is_last))
      else $error("job ended without a last result");

endmodule

bind lcs_with_traceback_core lcs_with_traceback_core_checker u_checker (.*);

// ===== tb/sv/lcs_result_check.sv =====
`timescale 1ns / 100ps
// lcs_result_check: watches the req_/rsp_ channels of the lcs traceback core, predicts
// the common subsequence of each loaded string pair and compares every rsp_ word
// depends on lcs_pkg for the word types and MAX_LEN

module lcs_result_check
   import lcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  lcs_req_type req_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  lcs_rsp_type rsp_word,
   output int          error_count,
   output int          pending_words
);

   logic [7:0]       first_buf  [MAX_LEN];
   logic [7:0]       second_buf [MAX_LEN];
   logic [LEN_W-1:0] first_count;
   logic [LEN_W-1:0] second_count;
   logic             first_closed;
   logic             trunc_seen;

   // suffix lcs lengths, rebuilt for every string pair
   logic [VAL_W-1:0] suffix_len [DIM][DIM];

   lcs_rsp_type      expected_chars [$];
   lcs_rsp_type      want;
   lcs_rsp_type      made;
   int               fail_total = 0;
   int               row, col, emitted;

   task automatic note_mismatch(input string field, input int exp_val, input int got_val);
      $display("%0t: rsp %s mismatch, expected %0h, actual %0h",
               $time, field, exp_val, got_val);
      fail_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_count  = '0;
         second_count = '0;
         first_closed = 1'b0;
         trunc_seen   = 1'b0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: rsp word with nothing expected, expected none, actual %0h",
                        $time, rsp_word);
               fail_total++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_word.out_byte !== want.out_byte)
                  note_mismatch("out_byte", want.out_byte, rsp_word.out_byte);
               if (rsp_word.is_last !== want.is_last)
                  note_mismatch("is_last", want.is_last, rsp_word.is_last);
               if (rsp_word.is_empty !== want.is_empty)
                  note_mismatch("is_empty", want.is_empty, rsp_word.is_empty);
               if (rsp_word.overflowed !== want.overflowed)
                  note_mismatch("overflowed", want.overflowed, rsp_word.overflowed);
            end
         end

         if (req_valid && req_ready) begin
            if (!first_closed) begin
               // words for the second string are dropped while the first loads
               if (req_word.which_string == WHICH_FIRST) begin
                  if (first_count < MAX_LEN) begin
                     first_buf[first_count] = req_word.char_byte;
                     first_count = first_count + 1'b1;
                  end else begin
                     trunc_seen = 1'b1;
                  end
                  if (req_word.end_of_string)
                     first_closed = 1'b1;
               end
            end else if (req_word.which_string == WHICH_SECOND) begin
               if (second_count < MAX_LEN) begin
                  second_buf[second_count] = req_word.char_byte;
                  second_count = second_count + 1'b1;
               end else begin
                  trunc_seen = 1'b1;
               end

               if (req_word.end_of_string) begin
                  // zero boundary row and column, then fill backward
                  for (row = 0; row <= first_count; row++)
                     suffix_len[row][second_count] = '0;
                  for (col = 0; col <= second_count; col++)
                     suffix_len[first_count][col] = '0;
                  for (row = first_count - 1; row >= 0; row--) begin
                     for (col = second_count - 1; col >= 0; col--) begin
                        if (first_buf[row] == second_buf[col])
                           suffix_len[row][col] = suffix_len[row + 1][col + 1] + 1'b1;
                        else if (suffix_len[row + 1][col] > suffix_len[row][col + 1])
                           suffix_len[row][col] = suffix_len[row + 1][col];
                        else
                           suffix_len[row][col] = suffix_len[row][col + 1];
                     end
                  end

                  made.overflowed = trunc_seen;
                  if (suffix_len[0][0] == 0) begin
                     made.out_byte = 8'h00;
                     made.is_last  = 1'b1;
                     made.is_empty = 1'b1;
                     expected_chars = {expected_chars, made};
                  end else begin
                     // forward walk: match, else skip in first, else skip in second
                     row = 0;
                     col = 0;
                     emitted = 0;
                     made.is_empty = 1'b0;
                     while (row < first_count && col < second_count) begin
                        if (first_buf[row] == second_buf[col] &&
                            suffix_len[row + 1][col + 1] + 1 == suffix_len[row][col]) begin
                           emitted++;
                           made.out_byte = first_buf[row];
                           made.is_last  = (emitted == suffix_len[0][0]);
                           expected_chars = {expected_chars, made};
                           row++;
                           col++;
                        end else if (suffix_len[row + 1][col] == suffix_len[row][col]) begin
                           row++;
                        end else begin
                           col++;
                        end
                     end
                  end

                  first_count  = '0;
                  second_count = '0;
                  first_closed = 1'b0;
                  trunc_seen   = 1'b0;
               end
            end
         end
      end
      error_count   <= fail_total;
      pending_words <= expected_chars.size();
   end

endmodule

// ===== tb/sv/lcs_with_traceback_core_tb.sv =====
`timescale 1ns / 100ps
// lcs_with_traceback_core_tb: stimulus, handshake pressure and verdict for the lcs core
// depends on lcs_pkg, lcs_with_traceback_core and lcs_result_check

module lcs_with_traceback_core_tb;
   import lcs_pkg::*;

   localparam int ITEM_TARGET    = 360;
   localparam int LONG_HOLD      = 1200;
   localparam int DRAIN_CYCLES   = 600;
   localparam int WATCHDOG_LIMIT = 30000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lcs_req_type req_word  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lcs_rsp_type rsp_word;

   int          error_count;
   int          pending_words;
   int          items_sent   = 0;
   int          quiet_cycles = 0;

   // set by the sender; hold_go and calm are read by the receiver too
   bit          hold_go    = 1'b0;  // asks the receiver for its one long hold-off
   bit          calm       = 1'b0;  // last part of the run, no idling anywhere
   bit          send_quiet = 1'b0;  // this job is sent back to back

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lcs_with_traceback_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   lcs_result_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   // one word on the req_ channel, with an occasional idle burst in front of it;
   // valid is raised at the falling edge and held until the word is taken
   task automatic offer(input logic which, input logic [7:0] ch, input logic eos,
                        input bit counts);
      lcs_req_type w;
      w.which_string  = which;
      w.char_byte     = ch;
      w.end_of_string = eos;
      if (!calm && !send_quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counts)
         items_sent++;
   endtask

   // sender pause: nothing offered until every predicted word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // one job: both strings drawn from span characters above one random base so that common
   // characters are frequent for a small span; noise words for the wrong string are mixed in
   task automatic run_job(input int len_a, input int len_b, input int span,
                          input int noise_pct);
      logic [7:0] base;
      int         k;
      base = 8'($urandom);
      for (k = 0; k < len_a; k++) begin
         if ($urandom_range(0, 99) < noise_pct)
            offer(WHICH_SECOND, 8'($urandom), 1'($urandom), 1'b0);
         offer(WHICH_FIRST, base + 8'($urandom_range(0, span - 1)), k == len_a - 1, 1'b1);
      end
      for (k = 0; k < len_b; k++) begin
         if ($urandom_range(0, 99) < noise_pct)
            offer(WHICH_FIRST, 8'($urandom), 1'($urandom), 1'b0);
         offer(WHICH_SECOND, base + 8'($urandom_range(0, span - 1)), k == len_b - 1, 1'b1);
      end
   endtask

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts, quiet stretches, and one long hold-off
   // that backs the core up until it stops taking req_ words
   initial begin : rsp_side
      int mode_left;
      bit rsp_quiet;
      bit hold_taken;
      mode_left  = 0;
      rsp_quiet  = 1'b0;
      hold_taken = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (mode_left == 0) begin
            mode_left = 150;
            rsp_quiet = ($urandom_range(0, 2) == 0);
         end
         mode_left--;
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!calm && !rsp_quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin : req_side
      int job;
      int kind;
      int len_a;
      int len_b;
      int span;
      int noise_pct;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-character match on 0x00; noise for the wrong string, end mark set,
      // before the first string and again while the second loads
      offer(WHICH_SECOND, 8'hFF, 1'b1, 1'b0);
      offer(WHICH_FIRST,  8'h00, 1'b1, 1'b1);
      offer(WHICH_FIRST,  8'hFF, 1'b1, 1'b0);
      offer(WHICH_SECOND, 8'h00, 1'b1, 1'b1);
      // nothing in common: one empty word
      offer(WHICH_FIRST,  8'hFF, 1'b1, 1'b1);
      offer(WHICH_SECOND, 8'h00, 1'b1, 1'b1);
      // mismatch at the start, walk has to skip in the first string
      offer(WHICH_FIRST,  8'hFF, 1'b0, 1'b1);
      offer(WHICH_FIRST,  8'h80, 1'b1, 1'b1);
      offer(WHICH_SECOND, 8'h80, 1'b0, 1'b1);
      offer(WHICH_SECOND, 8'hFF, 1'b1, 1'b1);
      // rotated string, tie between two paths
      offer(WHICH_FIRST,  8'h41, 1'b0, 1'b1);
      offer(WHICH_FIRST,  8'h42, 1'b0, 1'b1);
      offer(WHICH_FIRST,  8'h43, 1'b1, 1'b1);
      offer(WHICH_SECOND, 8'h43, 1'b0, 1'b1);
      offer(WHICH_SECOND, 8'h41, 1'b0, 1'b1);
      offer(WHICH_SECOND, 8'h42, 1'b1, 1'b1);
      // identical strings, every character common
      offer(WHICH_FIRST,  8'h55, 1'b0, 1'b1);
      offer(WHICH_FIRST,  8'hAA, 1'b0, 1'b1);
      offer(WHICH_FIRST,  8'h55, 1'b0, 1'b1);
      offer(WHICH_FIRST,  8'hAA, 1'b1, 1'b1);
      offer(WHICH_SECOND, 8'h55, 1'b0, 1'b1);
      offer(WHICH_SECOND, 8'hAA, 1'b0, 1'b1);
      offer(WHICH_SECOND, 8'h55, 1'b0, 1'b1);
      offer(WHICH_SECOND, 8'hAA, 1'b1, 1'b1);
      wait_drained();

      job = 0;
      while (items_sent < ITEM_TARGET) begin
         calm       = (items_sent >= ITEM_TARGET - 60);
         send_quiet = calm || ($urandom_range(0, 2) == 0);
         noise_pct  = ($urandom_range(0, 3) == 0) ? 15 : 0;
         case ($urandom_range(0, 4))
            0:       span = 1;
            1:       span = 2;
            2:       span = 4;
            3:       span = 16;
            default: span = 256;
         endcase
         case (job)
            // sixteen result words while the receiver holds off, then an
            // overflow job that has to wait behind them
            0: begin
               hold_go = 1'b1;
               len_a   = 16;
               len_b   = 16;
               span    = 1;
            end
            // end mark on a dropped character of the first string
            1: begin
               len_a = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
               len_b = $urandom_range(1, 8);
            end
            // same for the second string
            2: begin
               len_a = $urandom_range(1, 8);
               len_b = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
            end
            // full size without truncation
            3: begin
               len_a = MAX_LEN;
               len_b = MAX_LEN;
               span  = 4;
            end
            default: begin
               kind = $urandom_range(0, 99);
               if (kind < 4) begin
                  len_a = $urandom_range(MAX_LEN - 4, MAX_LEN + 4);
                  len_b = $urandom_range(MAX_LEN - 4, MAX_LEN + 4);
               end else if (kind < 16) begin
                  len_a = $urandom_range(9, 24);
                  len_b = $urandom_range(9, 24);
               end else begin
                  len_a = $urandom_range(1, 8);
                  len_b = $urandom_range(1, 8);
               end
            end
         endcase
         run_job(len_a, len_b, span, noise_pct);
         // the job behind the long hold-off is always offered at once
         if (!calm && job != 0 && $urandom_range(0, 5) == 0)
            wait_drained();
         job++;
      end

      // everything predicted has to come back, then a quiet spell for strays
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_words == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
